>>> src/scfla_pkg.sv
`default_nettype none
package scfla_pkg;

	// default sizing
	localparam int DEF_NUM_FRAMES  = 256;
	localparam int DEF_FRAME_BYTES = 4096;
	localparam int DEF_NUM_CLASSES = 8;

	// fixed geometry
	localparam int MAX_CLASSES = 8;
	localparam int CLS_W       = 3;
	localparam int CHUNK_LOG   = 4;
	localparam int ADDR_OUT_W  = 20;

	// operation codes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// result status codes
	typedef enum logic [3:0] {
		ST_ALLOC     = 4'd0,
		ST_FREED     = 4'd1,
		ST_TOO_LARGE = 4'd2,
		ST_NO_MEM    = 4'd3,
		ST_NULL      = 4'd4,
		ST_RANGE     = 4'd5,
		ST_UNOWNED   = 4'd6,
		ST_DOUBLE    = 4'd7,
		ST_MISALIGN  = 4'd8
	} status_t;

	// input word
	typedef struct packed {
		logic        opcode;
		logic [31:0] request_size;
		logic [7:0]  spare_frame;
		logic [31:0] free_address;
	} req_t;

	// result word
	typedef struct packed {
		logic [3:0]            status;
		logic [ADDR_OUT_W-1:0] chunk_address;
		logic                  frame_taken;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       grow_start;
		logic       grow_step;
		logic       grow_finish;
		logic       pop_issue;
		logic       pop_finish;
		logic       class_load;
		logic       walk_read;
		logic       walk_next;
		logic       push;
		logic       fail;
		logic [3:0] code;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_free;
		logic too_large;
		logic head_empty;
		logic spare_ok;
		logic addr_null;
		logic frame_oor;
		logic unowned;
		logic misaligned;
		logic cur_zero;
		logic cur_match;
		logic grow_last;
	} sts_t;

endpackage
`default_nettype wire

>>> src/size_class_free_list_allocator.sv
`default_nettype none
// channel   signals             handshake
// request   req (req_t)         taken at a clock edge with start high and busy low
// result    rsp (rsp_t)         valid for the one cycle that done is high
//
// a pop passes decode and pop before done; failures decided at decode go straight
// to done; a grow links the chunks of the new frame (up to 256) one by one in grow.
// a free passes decode and class, then walks the class list entry by entry (link walk).
// the link memory with registered read sets the walk step time.
// reset clears list heads and frame ownership; results cannot be stalled.
module size_class_free_list_allocator #(
	parameter int NUM_FRAMES  = scfla_pkg::DEF_NUM_FRAMES,
	parameter int FRAME_BYTES = scfla_pkg::DEF_FRAME_BYTES,
	parameter int NUM_CLASSES = scfla_pkg::DEF_NUM_CLASSES
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire scfla_pkg::req_t req,
	output logic                 busy,
	output logic                 done,
	output scfla_pkg::rsp_t      rsp
);
	scfla_pkg::cmd_t cmd;
	scfla_pkg::sts_t sts;

	// sequencer
	scfla_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// lists, memories and result word
	scfla_dp #(
		.NUM_FRAMES  (NUM_FRAMES),
		.FRAME_BYTES (FRAME_BYTES),
		.NUM_CLASSES (NUM_CLASSES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

`ifndef NO_ASSERTIONS
	// block is idle again right after a result word
	a_done_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("busy after result");

	// an accepted word never yields a result in the next cycle
	a_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("result too early");

	// only an allocation returns an address
	a_addr_only_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != scfla_pkg::ST_ALLOC) |-> (rsp.chunk_address == '0))
		else $error("address on non-allocation");

	// a claimed frame always ends in an allocation
	a_taken_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.frame_taken) |-> (rsp.status == scfla_pkg::ST_ALLOC))
		else $error("frame taken without allocation");
`endif

endmodule
`default_nettype wire

>>> src/scfla_dp.sv
`default_nettype none
module scfla_dp #(
	parameter int NUM_FRAMES  = scfla_pkg::DEF_NUM_FRAMES,
	parameter int FRAME_BYTES = scfla_pkg::DEF_FRAME_BYTES,
	parameter int NUM_CLASSES = scfla_pkg::DEF_NUM_CLASSES
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire scfla_pkg::req_t req,
	input  wire scfla_pkg::cmd_t cmd,
	output scfla_pkg::sts_t      sts,
	output scfla_pkg::rsp_t      rsp
);
	localparam int CLS_W  = scfla_pkg::CLS_W;
	localparam int CL     = scfla_pkg::CHUNK_LOG;
	localparam int FB_LOG = $clog2(FRAME_BYTES);
	localparam int FR_W   = $clog2(NUM_FRAMES);
	localparam int IDX_W  = FR_W + FB_LOG - CL;
	localparam int SLOTS  = NUM_FRAMES * (FRAME_BYTES / 16);
	localparam int PER_FR = FRAME_BYTES / 16;
	localparam int GCNT_W = $clog2(PER_FR);
	localparam int AO_W   = scfla_pkg::ADDR_OUT_W;

	// latched item
	logic             op_q;
	logic [7:0]       spare_q;
	logic [31:0]      addr_q;
	logic [CLS_W-1:0] cls_q;
	logic             too_large_q;

	// list state
	logic [IDX_W-1:0]      head_q [scfla_pkg::MAX_CLASSES];
	logic [IDX_W-1:0]      link_mem [SLOTS];
	logic [IDX_W-1:0]      link_rd_q;
	logic [CLS_W-1:0]      fclass_mem [NUM_FRAMES];
	logic [CLS_W-1:0]      fclass_q;
	logic [NUM_FRAMES-1:0] owned_q;
	logic                  owned_rd_q;

	// walk and grow registers
	logic [IDX_W-1:0]  cur_q;
	logic [IDX_W-1:0]  ptr_q;
	logic [IDX_W-1:0]  prev_q;
	logic [GCNT_W-1:0] cnt_q;
	scfla_pkg::rsp_t   rsp_q;

	logic [CLS_W-1:0]  sel_cls;
	logic              sel_none;
	logic [IDX_W-1:0]  head_cur;
	logic [FR_W-1:0]   spare_idx;
	logic [FR_W-1:0]   addr_frm;
	logic [IDX_W-1:0]  free_idx;
	logic [GCNT_W-1:0] grow_lastcnt;
	logic              link_we;
	logic [IDX_W-1:0]  link_waddr;
	logic [IDX_W-1:0]  link_wdata;
	logic [IDX_W-1:0]  link_raddr;

	// smallest class that fits
	always_comb begin
		sel_cls  = '0;
		sel_none = 1'b1;
		for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
			if (req.request_size <= (32'd16 << i)) begin
				sel_cls  = CLS_W'(i);
				sel_none = 1'b0;
			end
		end
	end

	// address slicing
	assign head_cur     = head_q[cls_q];
	assign spare_idx    = FR_W'(spare_q);
	assign addr_frm     = addr_q[FB_LOG +: FR_W];
	assign free_idx     = addr_q[CL +: IDX_W];
	assign grow_lastcnt = GCNT_W'((PER_FR >> cls_q) - 1);

	// status toward the controller
	always_comb begin
		sts.is_free    = (op_q == scfla_pkg::OP_FREE);
		sts.too_large  = too_large_q;
		sts.head_empty = (head_cur == '0);
		sts.spare_ok   = (spare_q != 8'd0) && (32'(spare_q) < 32'(NUM_FRAMES))
			&& !owned_q[spare_idx];
		sts.addr_null  = (addr_q == 32'd0);
		sts.frame_oor  = ((addr_q >> FB_LOG) >= 32'(NUM_FRAMES));
		sts.unowned    = !owned_rd_q || (32'(fclass_q) >= 32'(NUM_CLASSES));
		sts.misaligned = ((addr_q & ((32'd16 << fclass_q) - 32'd1)) != 32'd0);
		sts.cur_zero   = (cur_q == '0);
		sts.cur_match  = (cur_q == free_idx);
		sts.grow_last  = (cnt_q == grow_lastcnt);
	end

	// link port selection
	always_comb begin
		link_we    = cmd.grow_step | cmd.push;
		link_waddr = cmd.push ? free_idx : ptr_q;
		link_wdata = cmd.push ? head_cur : prev_q;
		link_raddr = cmd.pop_issue ? head_cur : cur_q;
	end

	// link memory
	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_waddr] <= link_wdata;
		end
		if (cmd.pop_issue || cmd.walk_read) begin
			link_rd_q <= link_mem[link_raddr];
		end
	end

	// frame owner memory
	always_ff @(posedge clk) begin
		if (cmd.grow_start) begin
			fclass_mem[spare_idx] <= cls_q;
		end
		fclass_q   <= fclass_mem[addr_frm];
		owned_rd_q <= owned_q[addr_frm];
	end

	// owner valid bits and list heads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owned_q <= '0;
			for (int i = 0; i < scfla_pkg::MAX_CLASSES; i++) begin
				head_q[i] <= '0;
			end
		end else begin
			if (cmd.grow_start) begin
				owned_q[spare_idx] <= 1'b1;
			end
			if (cmd.pop_finish) begin
				head_q[cls_q] <= link_rd_q;
			end else if (cmd.grow_finish) begin
				head_q[cls_q] <= prev_q;
			end else if (cmd.push) begin
				head_q[cls_q] <= free_idx;
			end
		end
	end

	// item, walk, grow and result registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q        <= req.opcode;
			spare_q     <= req.spare_frame;
			addr_q      <= req.free_address;
			cls_q       <= sel_cls;
			too_large_q <= sel_none;
		end
		if (cmd.class_load) begin
			cls_q <= fclass_q;
			cur_q <= head_q[fclass_q];
		end
		if (cmd.walk_next) begin
			cur_q <= link_rd_q;
		end
		if (cmd.grow_start) begin
			ptr_q  <= IDX_W'(spare_q) << (FB_LOG - CL);
			prev_q <= '0;
			cnt_q  <= '0;
		end
		if (cmd.grow_step) begin
			prev_q <= ptr_q;
			ptr_q  <= ptr_q + (IDX_W'(1) << cls_q);
			cnt_q  <= cnt_q + GCNT_W'(1);
		end
		if (cmd.fail) begin
			rsp_q.status        <= cmd.code;
			rsp_q.chunk_address <= '0;
			rsp_q.frame_taken   <= 1'b0;
		end else if (cmd.pop_finish) begin
			rsp_q.status        <= scfla_pkg::ST_ALLOC;
			rsp_q.chunk_address <= AO_W'({head_cur, 4'b0000});
			rsp_q.frame_taken   <= 1'b0;
		end else if (cmd.grow_finish) begin
			rsp_q.status        <= scfla_pkg::ST_ALLOC;
			rsp_q.chunk_address <= AO_W'({ptr_q, 4'b0000});
			rsp_q.frame_taken   <= 1'b1;
		end else if (cmd.push) begin
			rsp_q.status        <= scfla_pkg::ST_FREED;
			rsp_q.chunk_address <= '0;
			rsp_q.frame_taken   <= 1'b0;
		end
	end

	assign rsp = rsp_q;

endmodule
`default_nettype wire

>>> src/scfla_ctrl.sv
`default_nettype none
module scfla_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire scfla_pkg::sts_t sts,
	output scfla_pkg::cmd_t      cmd,
	output logic                 busy,
	output logic                 done
);
	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_DECODE = 8'b0000_0010,
		S_POP    = 8'b0000_0100,
		S_GROW   = 8'b0000_1000,
		S_CLASS  = 8'b0001_0000,
		S_WALK   = 8'b0010_0000,
		S_NEXT   = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_nx;

	// next state and datapath commands
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_nx = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.is_free) begin
					if (sts.addr_null) begin
						cmd.fail = 1'b1;
						cmd.code = scfla_pkg::ST_NULL;
						state_nx = S_DONE;
					end else if (sts.frame_oor) begin
						cmd.fail = 1'b1;
						cmd.code = scfla_pkg::ST_RANGE;
						state_nx = S_DONE;
					end else begin
						state_nx = S_CLASS;
					end
				end else if (sts.too_large) begin
					cmd.fail = 1'b1;
					cmd.code = scfla_pkg::ST_TOO_LARGE;
					state_nx = S_DONE;
				end else if (!sts.head_empty) begin
					cmd.pop_issue = 1'b1;
					state_nx      = S_POP;
				end else if (sts.spare_ok) begin
					cmd.grow_start = 1'b1;
					state_nx       = S_GROW;
				end else begin
					cmd.fail = 1'b1;
					cmd.code = scfla_pkg::ST_NO_MEM;
					state_nx = S_DONE;
				end
			end
			S_POP: begin
				cmd.pop_finish = 1'b1;
				state_nx       = S_DONE;
			end
			S_GROW: begin
				if (sts.grow_last) begin
					cmd.grow_finish = 1'b1;
					state_nx        = S_DONE;
				end else begin
					cmd.grow_step = 1'b1;
				end
			end
			S_CLASS: begin
				if (sts.unowned) begin
					cmd.fail = 1'b1;
					cmd.code = scfla_pkg::ST_UNOWNED;
					state_nx = S_DONE;
				end else if (sts.misaligned) begin
					cmd.fail = 1'b1;
					cmd.code = scfla_pkg::ST_MISALIGN;
					state_nx = S_DONE;
				end else begin
					cmd.class_load = 1'b1;
					state_nx       = S_WALK;
				end
			end
			S_WALK: begin
				if (sts.cur_zero) begin
					cmd.push = 1'b1;
					state_nx = S_DONE;
				end else if (sts.cur_match) begin
					cmd.fail = 1'b1;
					cmd.code = scfla_pkg::ST_DOUBLE;
					state_nx = S_DONE;
				end else begin
					cmd.walk_read = 1'b1;
					state_nx      = S_NEXT;
				end
			end
			S_NEXT: begin
				cmd.walk_next = 1'b1;
				state_nx      = S_WALK;
			end
			S_DONE: begin
				state_nx = S_IDLE;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

endmodule
`default_nettype wire
